[src/assert_macros.svh]
// Assertion macros used by the cache core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/horc_pkg.sv]
// Package of types, constants and the rotate helper for the result cache hash.
`default_nettype none
package horc_pkg;
  localparam int unsigned TableSize = 1024;
  localparam int unsigned IdxW = $clog2(TableSize);
  localparam int unsigned CntW = $clog2(TableSize + 1);
  localparam logic [31:0] HashSeed = 32'd5381;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MIX, ST_CLEAR, ST_SLOT, ST_ENTRY, ST_DONE
  } state_e;

  // One entry of the cache: owning slot, op byte, both operands and result.
  typedef struct packed {
    logic [IdxW-1:0] slot;
    logic [7:0]      op;
    logic [31:0]     opa;
    logic [31:0]     opb;
    logic [31:0]     res;
  } entry_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction
endpackage
`default_nettype wire

[src/hashed_operation_result_cache_core.sv]
// Top level: hash unit, slot and entry memories, and the access sequencer.
// The result strobe follows the start beat through 12 hash steps, the slot read, the entry read,
// the decision and the output register.
// busy_o is high after each start beat until the result is shown; a start beat while busy_o is high is ignored.
// Reset clears the fill count and control state, then a pass over every slot zeroes the slot map.
// The receiver cannot stall: each result is shown for a single cycle.
`default_nettype none
module hashed_operation_result_cache_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        mode_i,
  input  wire logic signed [7:0] op_code_i,
  input  wire logic [31:0] operand_a_i,
  input  wire logic [31:0] operand_b_i,
  input  wire logic [31:0] insert_value_i,
  output logic             valid_o,
  output logic             hit_o,
  output logic [31:0]      found_value_o
);
  import horc_pkg::*;
  `include "assert_macros.svh"

  state_e state_q, state_d;
  logic mode_q; logic [7:0] op_q; logic [31:0] a_q, b_q, v_q;
  logic [CntW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] slot_q, idx_q;
  logic hdone; logic [IdxW-1:0] hslot;
  logic [IdxW-1:0] slot_mem [TableSize];
  entry_t ent_mem [TableSize];
  logic [IdxW-1:0] slot_rd_q;
  entry_t ent_rd_q;
  logic owned, match, need_new, full, hstart;
  logic slot_we, ent_we; logic [IdxW-1:0] ent_waddr;
  logic [IdxW-1:0] slot_waddr, slot_wdata;
  logic [IdxW-1:0] clr_q, clr_d;
  logic hit_d;
  logic [31:0] val_d;

  assign hstart = start_i && !busy_o;

  horc_hash u_hash (
    .clk_i, .rst_ni, .start_i(hstart), .op_i(op_code_i),
    .a_i(operand_a_i), .b_i(operand_b_i), .done_o(hdone), .slot_o(hslot)
  );

  // Ownership and key compare on the registered entry read.
  assign owned = ({1'b0, idx_q} < fill_q) && (ent_rd_q.slot == slot_q);
  assign match = owned && ent_rd_q.op == op_q && ent_rd_q.opa == a_q
                 && ent_rd_q.opb == b_q;
  assign full = (fill_q == CntW'(TableSize));
  assign need_new = !owned;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == IdxW'(TableSize - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (hstart) state_d = ST_MIX;
      ST_MIX:   if (hdone) state_d = ST_SLOT;
      ST_SLOT:  state_d = ST_ENTRY;
      ST_ENTRY: state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and write enables.
  always_comb begin
    slot_we = 1'b0; ent_we = 1'b0; ent_waddr = idx_q; fill_d = fill_q;
    slot_waddr = slot_q; slot_wdata = fill_q[IdxW-1:0]; clr_d = clr_q;
    hit_d = 1'b0; val_d = 32'd0;
    if (state_q == ST_CLEAR) begin
      slot_we = 1'b1; slot_waddr = clr_q; slot_wdata = '0;
      clr_d = clr_q + 1'b1;
    end else if (state_q == ST_DONE) begin
      if (!mode_q) begin
        hit_d = match; val_d = match ? ent_rd_q.res : 32'hffff_ffff;
      end else if (!need_new) begin
        ent_we = 1'b1;
      end else if (!full) begin
        ent_we = 1'b1; slot_we = 1'b1; ent_waddr = fill_q[IdxW-1:0];
        fill_d = fill_q + 1'b1;
      end
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  // Slot memory cleared after reset, read when the hash is done, written on append; entries written on insert.
  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rd_q <= slot_mem[hslot];
    if (ent_we) ent_mem[ent_waddr] <= '{slot: slot_q, op: op_q, opa: a_q, opb: b_q, res: v_q};
    ent_rd_q <= ent_mem[slot_rd_q];
  end

  // Key capture and index staging.
  always_ff @(posedge clk_i) begin
    if (hstart) begin
      mode_q <= mode_i; op_q <= op_code_i; a_q <= operand_a_i;
      b_q <= operand_b_i; v_q <= insert_value_i;
    end
    if (hdone) slot_q <= hslot;
    if (state_q == ST_SLOT) idx_q <= slot_rd_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; fill_q <= '0; valid_o <= 1'b0; clr_q <= '0;
    end else begin
      state_q <= state_d; fill_q <= fill_d; valid_o <= (state_q == ST_DONE);
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o <= hit_d; found_value_o <= val_d;
  end

  `ASSERT_IMPL(a_fill_max, clk_i, rst_ni, 1'b1, fill_q <= CntW'(TableSize))
  `ASSERT_NEXT(a_one_strobe, clk_i, rst_ni, valid_o, !valid_o)
  `ASSERT_IMPL(a_ins_nohit, clk_i, rst_ni, valid_o && mode_q, !hit_o)
endmodule
`default_nettype wire

[src/horc_hash.sv]
// Sequential MurmurHash3 unit: at most one multiply per cycle, result reduced to a slot.
`default_nettype none
module horc_hash (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [7:0]               op_i,
  input  wire logic [31:0]              a_i,
  input  wire logic [31:0]              b_i,
  output logic                          done_o,
  output logic [horc_pkg::IdxW-1:0]     slot_o
);
  import horc_pkg::*;

  logic [31:0] h_q, h_d, k_q, k_d;
  logic [95:0] words_q, words_d;
  logic [3:0]  step_q, step_d;
  logic        busy_q, busy_d;

  // Steps 0..8: three words of three multiplies; 9..11 finaliser.
  always_comb begin
    h_d = h_q; k_d = k_q; words_d = words_q; step_d = step_q; busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      words_d = {{{24{op_i[7]}}, op_i}, a_i, b_i};
      h_d = HashSeed; step_d = 4'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      step_d = step_q + 4'd1;
      case (step_q)
        4'd0, 4'd3, 4'd6: k_d = words_q[95:64] * 32'hcc9e2d51;
        4'd1, 4'd4, 4'd7: k_d = rotl(k_q, 15) * 32'h1b873593;
        4'd2, 4'd5, 4'd8: begin
          h_d = rotl(h_q ^ k_q, 13) * 32'd5 + 32'he6546b64;
          words_d = {words_q[63:0], 32'd0};
        end
        4'd9: begin
          h_d = h_q ^ 32'd12;
          h_d = (h_d ^ (h_d >> 16)) * 32'h85ebca6b;
        end
        4'd10: h_d = (h_q ^ (h_q >> 13)) * 32'hc2b2ae35;
        4'd11: begin
          h_d = h_q ^ (h_q >> 16);
          busy_d = 1'b0; done_o = 1'b1;
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  assign slot_o = h_d[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; step_q <= '0;
    end else begin
      busy_q <= busy_d; step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d; k_q <= k_d; words_q <= words_d;
  end
endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the hashed operation result cache.
`timescale 1ns / 1ps
module tb;
  import horc_pkg::*;

  localparam int unsigned WatchLimit = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        mode_i;
  logic signed [7:0] op_code_i;
  logic [31:0] operand_a_i;
  logic [31:0] operand_b_i;
  logic [31:0] insert_value_i;
  logic        valid_o;
  logic        hit_o;
  logic [31:0] found_value_o;

  hashed_operation_result_cache_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .mode_i(mode_i), .op_code_i(op_code_i), .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i), .insert_value_i(insert_value_i),
    .valid_o(valid_o), .hit_o(hit_o), .found_value_o(found_value_o)
  );

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
  } answer_t;

  // Shadow copy of the cache contents.
  logic [IdxW-1:0] shadow_slot_map [TableSize];
  logic [IdxW-1:0] shadow_owner    [TableSize];
  logic [7:0]      shadow_op       [TableSize];
  logic [31:0]     shadow_opa      [TableSize];
  logic [31:0]     shadow_opb      [TableSize];
  logic [31:0]     shadow_res      [TableSize];
  int unsigned     shadow_fill;

  answer_t     pending_answers [$];
  int          error_count;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned items_sent;
  int unsigned hits_seen;
  logic [31:0] key_pool_a [16];
  logic [31:0] key_pool_b [16];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] kk;
    logic [31:0] hh;
    kk = k * 32'hcc9e2d51;
    kk = {kk[16:0], kk[31:17]};
    kk = kk * 32'h1b873593;
    hh = h ^ kk;
    hh = {hh[18:0], hh[31:19]};
    return hh * 32'd5 + 32'he6546b64;
  endfunction

  function automatic logic [IdxW-1:0] key_to_slot(input logic [7:0] op,
                                                  input logic [31:0] a,
                                                  input logic [31:0] b);
    logic [31:0] h;
    h = mix_word(HashSeed, {{24{op[7]}}, op});
    h = mix_word(h, a);
    h = mix_word(h, b);
    h = h ^ 32'd12;
    h = h ^ (h >> 16);
    h = h * 32'h85ebca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2ae35;
    h = h ^ (h >> 16);
    return IdxW'(h % TableSize);
  endfunction

  // Work out the answer to one access and update the shadow contents.
  function automatic answer_t cache_access(input logic md, input logic [7:0] op,
                                           input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] val);
    logic [IdxW-1:0] slot;
    int unsigned     idx;
    logic            owned;
    answer_t         ans;
    slot = key_to_slot(op, a, b);
    idx = shadow_slot_map[slot];
    owned = (idx < shadow_fill) && (shadow_owner[idx] == slot);
    ans = '{hit: 1'b0, value: 32'd0};
    if (!md) begin
      if (owned && shadow_op[idx] == op && shadow_opa[idx] == a && shadow_opb[idx] == b)
        ans = '{hit: 1'b1, value: shadow_res[idx]};
      else
        ans.value = 32'hFFFFFFFF;
      return ans;
    end
    if (!owned) begin
      if (shadow_fill >= TableSize) return ans;
      idx = shadow_fill;
      shadow_slot_map[slot] = IdxW'(idx);
      shadow_fill++;
    end
    shadow_owner[idx] = slot;
    shadow_op[idx] = op;
    shadow_opa[idx] = a;
    shadow_opb[idx] = b;
    shadow_res[idx] = val;
    return ans;
  endfunction

  // Send one beat once the block is free, with a random gap before it.
  task automatic send_access(input logic md, input logic [7:0] op, input logic [31:0] a,
                             input logic [31:0] b, input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    start_i <= 1'b1;
    mode_i <= md;
    op_code_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    insert_value_i <= val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_answers.push_back(cache_access(md, op, a, b, val));
    items_sent++;
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Compare each result beat with the oldest expected answer.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && valid_o) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result hit=%0b value=%h", $time, hit_o, found_value_o);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (hit_o) hits_seen++;
        if (hit_o !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit_o);
          error_count++;
        end
        if (found_value_o !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, found_value_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat or result.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Boundary keys, signed op codes, all-ones results and lookups that miss.
  task automatic test_directed();
    send_access(1'b0, 8'h00, 32'h0, 32'h0, 32'h0);
    send_access(1'b1, 8'h00, 32'h0, 32'h0, 32'h12345678);
    send_access(1'b0, 8'h00, 32'h0, 32'h0, 32'h0);
    send_access(1'b1, 8'h80, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_access(1'b0, 8'h80, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
    send_access(1'b0, 8'h7F, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
    send_access(1'b1, 8'h7F, 32'h0, 32'hFFFFFFFF, 32'hAAAAAAAA);
    send_access(1'b1, 8'h7F, 32'h0, 32'hFFFFFFFF, 32'h55555555);
    send_access(1'b0, 8'h7F, 32'h0, 32'hFFFFFFFF, 32'h0);
    send_access(1'b0, 8'hFF, 32'h0, 32'hFFFFFFFF, 32'h0);
    send_access(1'b0, 8'h7F, 32'h1, 32'hFFFFFFFF, 32'h0);
  endtask

  // Random traffic over a small key pool so that hits and rewrites are common.
  task automatic test_random(input int unsigned count);
    logic [7:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    int unsigned k;
    repeat (count) begin
      k = $urandom_range(15);
      if ($urandom_range(3) == 0) begin
        op = 8'($urandom);
        a = $urandom;
        b = $urandom;
      end else begin
        op = 8'(k * 37);
        a = key_pool_a[k];
        b = key_pool_b[k];
      end
      send_access(1'($urandom), op, a, b, $urandom);
    end
  endtask

  // Fill every slot with a key chosen to land on a free slot, then keep inserting and probing.
  task automatic test_full_table();
    logic [7:0]      op;
    logic [31:0]     a;
    logic [31:0]     b;
    logic [IdxW-1:0] slot;
    int unsigned     idx;
    while (shadow_fill < TableSize) begin
      do begin
        op = 8'($urandom);
        a = $urandom;
        b = $urandom;
        slot = key_to_slot(op, a, b);
        idx = shadow_slot_map[slot];
      end while ((idx < shadow_fill) && (shadow_owner[idx] == slot));
      send_access(1'b1, op, a, b, $urandom);
    end
    repeat (20) send_access(1'b1, 8'($urandom), $urandom, $urandom, $urandom);
    test_random(60);
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    mode_i = 1'b0;
    op_code_i = '0;
    operand_a_i = '0;
    operand_b_i = '0;
    insert_value_i = '0;
    error_count = 0;
    idle_cycles = 0;
    items_sent = 0;
    hits_seen = 0;
    shadow_fill = 0;
    send_idle_pct = 30;
    for (int i = 0; i < TableSize; i++) shadow_slot_map[i] = '0;
    for (int i = 0; i < 16; i++) begin
      key_pool_a[i] = $urandom;
      key_pool_b[i] = $urandom;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(200);
    send_idle_pct = 71;
    test_random(200);
    send_idle_pct = 0;
    test_random(200);
    test_full_table();
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d accesses, %0d hits, table filled to %0d entries.",
             items_sent, hits_seen, shadow_fill);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
